// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, character constants and helper functions for the JSON
// string unescape decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoder mode. The unused code falls into the idle arm of every case.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX1 = 3'd3,
    MODE_HEX2 = 3'd4,
    MODE_HEX3 = 3'd5,
    MODE_HEX4 = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_BADHEX  = 2'd0,
    ERR_WIDE    = 2'd1,
    ERR_NOQUOTE = 2'd2
  } err_e;

  localparam int unsigned ByteW = 8;
  // Three hex digits are held; the fourth is combined on arrival.
  localparam int unsigned HexW  = 12;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
    err_e             code;
  } result_t;

  // Characters of interest.
  localparam logic [ByteW-1:0] ChrQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChrBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChrSlash  = 8'h2F;
  localparam logic [ByteW-1:0] ChrLowB   = 8'h62;
  localparam logic [ByteW-1:0] ChrLowT   = 8'h74;
  localparam logic [ByteW-1:0] ChrLowN   = 8'h6E;
  localparam logic [ByteW-1:0] ChrLowF   = 8'h66;
  localparam logic [ByteW-1:0] ChrLowR   = 8'h72;
  localparam logic [ByteW-1:0] ChrLowU   = 8'h75;

  // Decoded control characters.
  localparam logic [ByteW-1:0] CtlBs = 8'h08;
  localparam logic [ByteW-1:0] CtlHt = 8'h09;
  localparam logic [ByteW-1:0] CtlLf = 8'h0A;
  localparam logic [ByteW-1:0] CtlFf = 8'h0C;
  localparam logic [ByteW-1:0] CtlCr = 8'h0D;

  // Hex digit check: bit 4 is set for a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== design/json_string_unescape_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Decodes one quoted JSON string from a stream of raw text bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one raw text byte per transfer (in_valid_i,
// in_stall_o, text_byte_i). The output channel carries zero or one result
// per input byte (out_valid_o, out_stall_i, out_byte_o, result_kind_o,
// error_code_o). A transfer happens at a rising edge where valid is high and
// stall is low.
// A byte lands in the input register, then the decode logic writes its result
// into the output register at the next edge unless the output is stalled. One
// byte is taken every cycle while the receiver does not stall.
// Bytes that produce no result (opening quote, backslash, hex digits before
// the last, unknown escape letters) still leave the input register as usual.
// When the receiver stalls, the output register holds its result and an empty
// input register takes one more byte; after that in_stall_o rises.
// Reset clears both valid bits and returns the decoder to idle, outside any
// string, with the collected hex value at zero.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] result_kind_o,
  output logic [1:0] error_code_o
);
  import jsu_pkg::*;

  // Input register stage.
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_xfer;

  // Decoder state.
  mode_e            mode_q, mode_d;
  logic [HexW-1:0]  hex_q, hex_d;

  logic             res_valid;
  result_t          res;
  logic             can_load;
  logic             advance;
  result_t          out_res;

  // The held byte is decoded when the result register can take a result.
  assign advance    = in_vld_q && can_load;
  assign in_stall_o = in_vld_q && !can_load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_IDLE;
      hex_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (advance) begin
        mode_q <= mode_d;
        hex_q  <= hex_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= text_byte_i;
    end
  end

  jsu_decode u_decode (
    .mode_i      (mode_q),
    .hex_i       (hex_q),
    .byte_i      (in_byte_q),
    .mode_o      (mode_d),
    .hex_o       (hex_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  jsu_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .res_i      (res),
    .stall_i    (out_stall_i),
    .can_load_o (can_load),
    .valid_o    (out_valid_o),
    .res_o      (out_res)
  );

  assign out_byte_o    = out_res.data;
  assign result_kind_o = out_res.kind;
  assign error_code_o  = out_res.code;

  // Every error sends the decoder back to idle with the hex value cleared.
  a_err_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && res.kind == KIND_ERR) |=> (mode_q == MODE_IDLE && hex_q == '0))
    else $error("error result did not return decoder to idle");

  // The input side stalls only while a byte is held.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with empty input register");

  // Unused fields of end and error results are zero.
  a_unused_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != KIND_BYTE) |-> out_byte_o == '0)
    else $error("out_byte nonzero in end or error result");

  a_unused_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != KIND_ERR) |-> error_code_o == ERR_BADHEX)
    else $error("error_code nonzero outside error result");

endmodule

// ===== design/jsu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape decode logic
// Next-mode, hex accumulation and result selection for one text byte.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::mode_e                    mode_i,
  input  logic [jsu_pkg::HexW-1:0]          hex_i,
  input  logic [jsu_pkg::ByteW-1:0]         byte_i,
  output jsu_pkg::mode_e                    mode_o,
  output logic [jsu_pkg::HexW-1:0]          hex_o,
  output logic                              res_valid_o,
  output jsu_pkg::result_t                  res_o
);
  import jsu_pkg::*;

  logic [4:0] dig;

  assign dig = hex_digit(byte_i);

  always_comb begin
    mode_o      = mode_i;
    hex_o       = hex_i;
    res_valid_o = 1'b0;
    res_o       = '{data: '0, kind: KIND_BYTE, code: ERR_BADHEX};
    case (mode_i)
      MODE_STR: begin
        if (byte_i == ChrQuote) begin
          mode_o      = MODE_IDLE;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_END;
        end else if (byte_i == ChrBslash) begin
          mode_o = MODE_ESC;
        end else begin
          res_valid_o = 1'b1;
          res_o.data  = byte_i;
        end
      end
      MODE_ESC: begin
        mode_o      = MODE_STR;
        res_valid_o = 1'b1;
        case (byte_i)
          ChrLowB:   res_o.data = CtlBs;
          ChrLowT:   res_o.data = CtlHt;
          ChrLowN:   res_o.data = CtlLf;
          ChrLowF:   res_o.data = CtlFf;
          ChrLowR:   res_o.data = CtlCr;
          ChrBslash: res_o.data = ChrBslash;
          ChrQuote:  res_o.data = ChrQuote;
          ChrSlash:  res_o.data = ChrSlash;
          ChrLowU: begin
            res_valid_o = 1'b0;
            hex_o       = '0;
            mode_o      = MODE_HEX1;
          end
          default: begin
            // Unknown escape letters are dropped.
            res_valid_o = 1'b0;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (!dig[4]) begin
          mode_o      = MODE_IDLE;
          hex_o       = '0;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ERR;
          res_o.code  = ERR_BADHEX;
        end else if (mode_i == MODE_HEX4) begin
          hex_o       = '0;
          res_valid_o = 1'b1;
          if (|hex_i[HexW-1:4]) begin
            mode_o     = MODE_IDLE;
            res_o.kind = KIND_ERR;
            res_o.code = ERR_WIDE;
          end else begin
            mode_o     = MODE_STR;
            res_o.data = {hex_i[3:0], dig[3:0]};
          end
        end else begin
          hex_o = {hex_i[HexW-5:0], dig[3:0]};
          case (mode_i)
            MODE_HEX1: mode_o = MODE_HEX2;
            MODE_HEX2: mode_o = MODE_HEX3;
            default:   mode_o = MODE_HEX4;
          endcase
        end
      end
      default: begin
        if (byte_i == ChrQuote) begin
          mode_o = MODE_STR;
          hex_o  = '0;
        end else begin
          hex_o       = '0;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ERR;
          res_o.code  = ERR_NOQUOTE;
        end
      end
    endcase
  end

endmodule

// ===== design/jsu_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module jsu_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jsu_pkg::result_t res_i,
  input  logic             stall_i,
  output logic             can_load_o,
  output logic             valid_o,
  output jsu_pkg::result_t res_o
);
  import jsu_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // Free, or the held result leaves at this edge.
  assign can_load_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (can_load_o) begin
      valid_d = load_i;
      if (load_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
